@@ design/cle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the circular list engine: request kinds,
// result status codes, sequencer states and field widths.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int NODES_DEF = 16;
    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 5;

    typedef enum logic [KIND_W-1:0] {
        K_INS_HEAD = 2'd0,
        K_INS_TAIL = 2'd1,
        K_DELETE   = 2'd2,
        K_DUMP     = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_POP,
        S_INS_TAIL,
        S_INS_LINK,
        S_INS_FIX,
        S_DEL_HEAD,
        S_DEL_CMP,
        S_DEL_FREE,
        S_DMP_HEAD,
        S_DMP_OUT,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ design/cle_node_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_node_store
// Node pool storage: value and link memories, one write port each and a
// shared registered read address.
// ----------------------------------------------------------------------------
module cle_node_store #(
    parameter int NODES = cle_pkg::NODES_DEF,
    localparam int SW   = $clog2(NODES)
) (
    input  wire logic                               i_clk,
    input  wire logic [SW-1:0]                      i_rd_addr,
    output logic signed [cle_pkg::VALUE_W-1:0]      o_value_rd,
    output logic [SW-1:0]                           o_link_rd,
    input  wire logic                               i_value_we,
    input  wire logic [SW-1:0]                      i_value_waddr,
    input  wire logic signed [cle_pkg::VALUE_W-1:0] i_value_wdata,
    input  wire logic                               i_link_we,
    input  wire logic [SW-1:0]                      i_link_waddr,
    input  wire logic [SW-1:0]                      i_link_wdata
);

    logic signed [cle_pkg::VALUE_W-1:0] r_value_mem [NODES];
    logic [SW-1:0]                      r_link_mem  [NODES];

    always_ff @(posedge i_clk) begin
        if (i_value_we) begin
            r_value_mem[i_value_waddr] <= i_value_wdata;
        end
        o_value_rd <= r_value_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        o_link_rd <= r_link_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ design/circular_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list with a tail pointer, kept in a node pool.
// ----------------------------------------------------------------------------
// One request is worked at a time; o_ready is high only while the sequencer
// is idle. Every link and value access goes through the single read port of
// the node store, whose data arrives in the cycle after the address, so the
// list walk advances one node per cycle unless a held result stalls a dump.
// An insert that reuses a freed slot first pops it off the chain of freed
// slots. A delete walks from the head to the first match and, when found,
// returns its slot to that chain. A dump gives one result per cycle, head
// first, while the output side takes them. Results pass through an output
// register, so a new request may be accepted while the last result of the
// previous one still waits. A delete or dump on an empty list, or an insert
// on a full list, returns a single result with a status. The node memories
// are not cleared after reset; slots are handed out first from a fill
// counter, then from a chain of freed slots.
// ----------------------------------------------------------------------------
module circular_list_engine #(
    parameter int NODES = cle_pkg::NODES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [cle_pkg::KIND_W-1:0]           i_kind,
    input  wire logic signed [cle_pkg::VALUE_W-1:0]   i_value,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [cle_pkg::STATUS_W-1:0]              o_status,
    output logic signed [cle_pkg::VALUE_W-1:0]        o_out_value,
    output logic [cle_pkg::ENTRIES_W-1:0]             o_entries,
    output logic                                      o_last
);

    localparam int SW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    cle_pkg::t_state                    r_state, n_state;
    cle_pkg::t_kind                     r_kind, n_kind;
    cle_pkg::t_status                   r_status, n_status;
    logic signed [cle_pkg::VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_fresh, n_fresh;
    logic [CW-1:0]                      r_idx, n_idx;
    logic [SW-1:0]                      r_tail, n_tail;
    logic [SW-1:0]                      r_free_head, n_free_head;
    logic [SW-1:0]                      r_slot, n_slot;
    logic [SW-1:0]                      r_cur, n_cur;
    logic [SW-1:0]                      r_prev, n_prev;

    logic                               r_out_valid;
    cle_pkg::t_status                   r_out_status;
    logic signed [cle_pkg::VALUE_W-1:0] r_out_value;
    logic [cle_pkg::ENTRIES_W-1:0]      r_out_entries;
    logic                               r_out_last;

    logic                               out_free;
    logic                               out_load;
    cle_pkg::t_status                   out_status;
    logic signed [cle_pkg::VALUE_W-1:0] out_value;
    logic                               out_last;
    logic                               in_xfer;
    logic                               at_end;

    logic [SW-1:0]                      rd_addr;
    logic signed [cle_pkg::VALUE_W-1:0] value_rd;
    logic [SW-1:0]                      link_rd;
    logic                               value_we;
    logic [SW-1:0]                      value_waddr;
    logic                               link_we;
    logic [SW-1:0]                      link_waddr;
    logic [SW-1:0]                      link_wdata;

    cle_node_store #(
        .NODES (NODES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_addr     (rd_addr),
        .o_value_rd    (value_rd),
        .o_link_rd     (link_rd),
        .i_value_we    (value_we),
        .i_value_waddr (value_waddr),
        .i_value_wdata (r_value),
        .i_link_we     (link_we),
        .i_link_waddr  (link_waddr),
        .i_link_wdata  (link_wdata)
    );

    assign o_ready     = (r_state == cle_pkg::S_IDLE);
    assign in_xfer     = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign at_end      = ((r_idx + CW'(1)) == r_count);

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_value = r_out_value;
    assign o_entries   = r_out_entries;
    assign o_last      = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_status    = r_status;
        n_value     = r_value;
        n_count     = r_count;
        n_fresh     = r_fresh;
        n_idx       = r_idx;
        n_tail      = r_tail;
        n_free_head = r_free_head;
        n_slot      = r_slot;
        n_cur       = r_cur;
        n_prev      = r_prev;
        rd_addr     = r_cur;
        value_we    = 1'b0;
        value_waddr = r_slot;
        link_we     = 1'b0;
        link_waddr  = r_slot;
        link_wdata  = r_slot;
        out_load    = 1'b0;
        out_status  = r_status;
        out_value   = r_value;
        out_last    = 1'b1;

        unique case (r_state)
            cle_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_kind  = cle_pkg::t_kind'(i_kind);
                    n_value = i_value;
                    unique case (cle_pkg::t_kind'(i_kind))
                        cle_pkg::K_INS_HEAD, cle_pkg::K_INS_TAIL: begin
                            if (r_count == CW'(NODES)) begin
                                n_status = cle_pkg::ST_FULL;
                                n_state  = cle_pkg::S_EMIT;
                            end else if (r_fresh != CW'(NODES)) begin
                                n_slot  = r_fresh[SW-1:0];
                                n_fresh = r_fresh + CW'(1);
                                n_state = cle_pkg::S_INS_TAIL;
                            end else begin
                                n_slot  = r_free_head;
                                rd_addr = r_free_head;
                                n_state = cle_pkg::S_INS_POP;
                            end
                        end
                        cle_pkg::K_DELETE: begin
                            if (r_count == '0) begin
                                n_status = cle_pkg::ST_EMPTY;
                                n_state  = cle_pkg::S_EMIT;
                            end else begin
                                n_prev  = r_tail;
                                rd_addr = r_tail;
                                n_state = cle_pkg::S_DEL_HEAD;
                            end
                        end
                        cle_pkg::K_DUMP: begin
                            if (r_count == '0) begin
                                n_status = cle_pkg::ST_EMPTY;
                                n_value  = '0;
                                n_state  = cle_pkg::S_EMIT;
                            end else begin
                                rd_addr = r_tail;
                                n_state = cle_pkg::S_DMP_HEAD;
                            end
                        end
                        default: n_state = cle_pkg::S_IDLE;
                    endcase
                end
            end
            cle_pkg::S_INS_POP: begin
                n_free_head = link_rd;
                n_state     = cle_pkg::S_INS_TAIL;
            end
            cle_pkg::S_INS_TAIL: begin
                value_we = 1'b1;
                if (r_count == '0) begin
                    link_we  = 1'b1;
                    n_tail   = r_slot;
                    n_count  = r_count + CW'(1);
                    n_status = cle_pkg::ST_OK;
                    n_state  = cle_pkg::S_EMIT;
                end else begin
                    rd_addr = r_tail;
                    n_state = cle_pkg::S_INS_LINK;
                end
            end
            cle_pkg::S_INS_LINK: begin
                link_we    = 1'b1;
                link_wdata = link_rd;
                n_state    = cle_pkg::S_INS_FIX;
            end
            cle_pkg::S_INS_FIX: begin
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = r_slot;
                if (r_kind == cle_pkg::K_INS_TAIL) begin
                    n_tail = r_slot;
                end
                n_count  = r_count + CW'(1);
                n_status = cle_pkg::ST_OK;
                n_state  = cle_pkg::S_EMIT;
            end
            cle_pkg::S_DEL_HEAD: begin
                n_cur   = link_rd;
                rd_addr = link_rd;
                n_idx   = '0;
                n_state = cle_pkg::S_DEL_CMP;
            end
            cle_pkg::S_DEL_CMP: begin
                if (value_rd == r_value) begin
                    if (r_count == CW'(1)) begin
                        n_tail = '0;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = r_prev;
                        link_wdata = link_rd;
                        if (r_cur == r_tail) begin
                            n_tail = r_prev;
                        end
                    end
                    n_count  = r_count - CW'(1);
                    n_status = cle_pkg::ST_OK;
                    n_state  = cle_pkg::S_DEL_FREE;
                end else if (at_end) begin
                    n_status = cle_pkg::ST_NOTFOUND;
                    n_state  = cle_pkg::S_EMIT;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_rd;
                    rd_addr = link_rd;
                    n_idx   = r_idx + CW'(1);
                end
            end
            cle_pkg::S_DEL_FREE: begin
                link_we     = 1'b1;
                link_waddr  = r_cur;
                link_wdata  = r_free_head;
                n_free_head = r_cur;
                n_state     = cle_pkg::S_EMIT;
            end
            cle_pkg::S_DMP_HEAD: begin
                n_cur   = link_rd;
                rd_addr = link_rd;
                n_idx   = '0;
                n_state = cle_pkg::S_DMP_OUT;
            end
            cle_pkg::S_DMP_OUT: begin
                rd_addr = r_cur;
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = cle_pkg::ST_OK;
                    out_value  = value_rd;
                    out_last   = at_end;
                    if (at_end) begin
                        n_state = cle_pkg::S_IDLE;
                    end else begin
                        n_cur   = link_rd;
                        rd_addr = link_rd;
                        n_idx   = r_idx + CW'(1);
                    end
                end
            end
            cle_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = cle_pkg::S_IDLE;
                end
            end
            default: n_state = cle_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cle_pkg::S_IDLE;
            r_count     <= '0;
            r_fresh     <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_fresh <= n_fresh;
            r_tail  <= n_tail;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_status    <= n_status;
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_free_head <= n_free_head;
        r_slot      <= n_slot;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        if (out_load) begin
            r_out_status  <= out_status;
            r_out_value   <= out_value;
            r_out_entries <= cle_pkg::ENTRIES_W'(n_count);
            r_out_last    <= out_last;
        end
    end

endmodule

`default_nettype wire

@@ design/cle_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks for the circular list engine, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker #(
    parameter int NODES = cle_pkg::NODES_DEF
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_valid,
    input wire logic                               o_ready,
    input wire logic [cle_pkg::KIND_W-1:0]         i_kind,
    input wire logic signed [cle_pkg::VALUE_W-1:0] i_value,
    input wire logic                               o_valid,
    input wire logic                               i_ready,
    input wire logic [cle_pkg::STATUS_W-1:0]       o_status,
    input wire logic signed [cle_pkg::VALUE_W-1:0] o_out_value,
    input wire logic [cle_pkg::ENTRIES_W-1:0]      o_entries,
    input wire logic                               o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_value) && $stable(o_status)
            && $stable(o_last))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == cle_pkg::ST_FULL)
            |-> o_entries == cle_pkg::ENTRIES_W'(NODES))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == cle_pkg::ST_EMPTY) |-> (o_entries == '0) && o_last)
        else $error("empty status with nodes in list");

    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != cle_pkg::ST_OK) |-> o_last)
        else $error("failed request without last");

endmodule

bind circular_list_engine cle_checker #(.NODES(NODES)) u_cle_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circular list engine. A queue-based list model
// predicts every result of each request. Directed tests cover the empty list,
// extreme values, duplicates, deletes at head, middle and tail, and a full
// list. A long output hold-off fills the block while requests keep coming.
// A random mix then alternates fill-heavy and drain-heavy phases. Both sides
// idle at random, with one stretch that has no idling.
// ----------------------------------------------------------------------------
module tb;

    localparam int POOL_SIZE   = cle_pkg::NODES_DEF;
    localparam int RANDOM_REQS = 196;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 32;

    typedef struct packed {
        cle_pkg::t_status                    status;
        logic signed [cle_pkg::VALUE_W-1:0]  value;
        logic [cle_pkg::ENTRIES_W-1:0]       entries;
        logic                                last;
    } t_list_reply;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_valid = 1'b0;
    logic                                   o_ready;
    logic [cle_pkg::KIND_W-1:0]             i_kind = '0;
    logic signed [cle_pkg::VALUE_W-1:0]     i_value = '0;
    logic                                   o_valid;
    logic                                   i_ready = 1'b0;
    logic [cle_pkg::STATUS_W-1:0]           o_status;
    logic signed [cle_pkg::VALUE_W-1:0]     o_out_value;
    logic [cle_pkg::ENTRIES_W-1:0]          o_entries;
    logic                                   o_last;

    logic signed [cle_pkg::VALUE_W-1:0]     list_values[$];
    t_list_reply                            pending_replies[$];
    bit                                     no_idle = 1'b0;
    int                                     sink_holdoff = 0;
    int                                     cycle_count = 0;
    int                                     mismatch_count = 0;
    int                                     replies_checked = 0;
    int                                     kind_count[4] = '{0, 0, 0, 0};
    int                                     full_hits = 0;
    int                                     empty_hits = 0;
    int                                     notfound_hits = 0;

    circular_list_engine #(
        .NODES(POOL_SIZE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_value (o_out_value),
        .o_entries   (o_entries),
        .o_last      (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void push_reply(cle_pkg::t_status st,
                                       logic signed [cle_pkg::VALUE_W-1:0] v, logic lst);
        t_list_reply r;
        r.status  = st;
        r.value   = v;
        r.entries = cle_pkg::ENTRIES_W'(list_values.size());
        r.last    = lst;
        pending_replies.push_back(r);
        case (st)
            cle_pkg::ST_FULL:     full_hits++;
            cle_pkg::ST_EMPTY:    empty_hits++;
            cle_pkg::ST_NOTFOUND: notfound_hits++;
            default: ;
        endcase
    endfunction

    function automatic void list_apply(cle_pkg::t_kind k,
                                       logic signed [cle_pkg::VALUE_W-1:0] v);
        int idx;
        kind_count[k]++;
        case (k)
            cle_pkg::K_INS_HEAD, cle_pkg::K_INS_TAIL: begin
                if (list_values.size() >= POOL_SIZE) begin
                    push_reply(cle_pkg::ST_FULL, v, 1'b1);
                end else begin
                    if (k == cle_pkg::K_INS_HEAD) list_values.push_front(v);
                    else list_values.push_back(v);
                    push_reply(cle_pkg::ST_OK, v, 1'b1);
                end
            end
            cle_pkg::K_DELETE: begin
                if (list_values.size() == 0) begin
                    push_reply(cle_pkg::ST_EMPTY, v, 1'b1);
                end else begin
                    idx = -1;
                    for (int i = 0; i < list_values.size(); i++) begin
                        if (idx < 0 && list_values[i] == v) idx = i;
                    end
                    if (idx < 0) begin
                        push_reply(cle_pkg::ST_NOTFOUND, v, 1'b1);
                    end else begin
                        list_values.delete(idx);
                        push_reply(cle_pkg::ST_OK, v, 1'b1);
                    end
                end
            end
            default: begin
                if (list_values.size() == 0) begin
                    push_reply(cle_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < list_values.size(); i++) begin
                        push_reply(cle_pkg::ST_OK, list_values[i],
                                   i == list_values.size() - 1);
                    end
                end
            end
        endcase
    endfunction

    task automatic send_request(cle_pkg::t_kind k, logic signed [cle_pkg::VALUE_W-1:0] v);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_kind  <= k;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        list_apply(k, v);
    endtask

    always begin
        @(negedge i_clk);
        if (sink_holdoff > 0) begin
            i_ready <= 1'b0;
            sink_holdoff <= sink_holdoff - 1;
        end else if (no_idle) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_list_reply exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: status %0d value %0d entries %0d last %0d",
                       o_status, o_out_value, o_entries, o_last);
                mismatch_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                replies_checked++;
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, o_status);
                    mismatch_count++;
                end
                if (o_out_value !== exp_r.value) begin
                    $error("out_value: expected %0d, actual %0d", exp_r.value, o_out_value);
                    mismatch_count++;
                end
                if (o_entries !== exp_r.entries) begin
                    $error("entries: expected %0d, actual %0d", exp_r.entries, o_entries);
                    mismatch_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, actual %0d", exp_r.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_request(cle_pkg::K_DUMP, 32'sd0);
        send_request(cle_pkg::K_DELETE, 32'sh5A5A_A5A5);
    endtask

    task automatic test_insert_extremes();
        send_request(cle_pkg::K_INS_HEAD, 32'sh7FFF_FFFF);
        send_request(cle_pkg::K_INS_TAIL, 32'sh8000_0000);
        send_request(cle_pkg::K_INS_HEAD, 32'sd0);
        send_request(cle_pkg::K_INS_TAIL, -32'sd1);
        send_request(cle_pkg::K_INS_HEAD, 32'sh7FFF_FFFF);
        send_request(cle_pkg::K_DUMP, 32'sd0);
    endtask

    task automatic test_delete_cases();
        send_request(cle_pkg::K_DELETE, 32'sd12345);
        send_request(cle_pkg::K_DELETE, 32'sh7FFF_FFFF);
        send_request(cle_pkg::K_DELETE, -32'sd1);
        send_request(cle_pkg::K_DELETE, 32'sh7FFF_FFFF);
        send_request(cle_pkg::K_DUMP, 32'sd0);
    endtask

    task automatic test_full_list();
        int fill;
        fill = POOL_SIZE - list_values.size();
        for (int i = 0; i < fill; i++) begin
            send_request((i % 2) ? cle_pkg::K_INS_TAIL : cle_pkg::K_INS_HEAD, $urandom);
        end
        send_request(cle_pkg::K_INS_HEAD, 32'sh1234_5678);
        send_request(cle_pkg::K_INS_TAIL, -32'sh1234_5678);
    endtask

    task automatic test_output_holdoff();
        @(negedge i_clk);
        sink_holdoff = 150;
        send_request(cle_pkg::K_DUMP, 32'sd0);
        send_request(cle_pkg::K_DELETE, list_values[POOL_SIZE - 1]);
        send_request(cle_pkg::K_DUMP, 32'sd0);
        send_request(cle_pkg::K_INS_TAIL, 32'sh0F0F_0F0F);
    endtask

    task automatic test_random_mix();
        int roll;
        cle_pkg::t_kind k;
        logic signed [cle_pkg::VALUE_W-1:0] v;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            no_idle = (n >= 100 && n < 150);
            roll = $urandom_range(99);
            if (((n / 40) % 2) == 0) begin
                k = (roll < 70) ? ((roll < 35) ? cle_pkg::K_INS_HEAD : cle_pkg::K_INS_TAIL)
                  : (roll < 85) ? cle_pkg::K_DELETE : cle_pkg::K_DUMP;
            end else begin
                k = (roll < 60) ? cle_pkg::K_DELETE
                  : (roll < 85) ? ((roll < 72) ? cle_pkg::K_INS_HEAD : cle_pkg::K_INS_TAIL)
                  : cle_pkg::K_DUMP;
            end
            roll = $urandom_range(99);
            if (k == cle_pkg::K_DELETE && list_values.size() > 0 && roll < 80) begin
                v = list_values[$urandom_range(list_values.size() - 1)];
            end else if (roll < 50) begin
                v = $urandom;
            end else if (roll < 75) begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = -32'sd1;
                    default: v = 32'sd0;
                endcase
            end else begin
                v = $urandom_range(7);
            end
            send_request(k, v);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_insert_extremes();
        test_delete_cases();
        test_full_list();
        test_output_holdoff();
        test_random_mix();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        $display("Requests: %0d head inserts, %0d tail inserts, %0d deletes, %0d dumps",
                 kind_count[cle_pkg::K_INS_HEAD], kind_count[cle_pkg::K_INS_TAIL],
                 kind_count[cle_pkg::K_DELETE], kind_count[cle_pkg::K_DUMP]);
        $display("Results checked: %0d (full %0d, empty %0d, not found %0d)",
                 replies_checked, full_hits, empty_hits, notfound_hits);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/cle_pkg.sv
design/cle_node_store.sv
design/circular_list_engine.sv
design/cle_checker.sv
test/tb.sv
